/* hdl/skel_pkg.sv */
`default_nettype none

package skel_pkg;

  localparam int WIN_DIM  = 5;
  localparam int WIN_BITS = WIN_DIM * WIN_DIM;
  localparam int CTR_BIT  = 2 * WIN_DIM + 2;
  localparam int COND_N   = 40;
  localparam int UNCOND_N = 26;

  // Patterns are written in reading order: the leftmost digit is cell 0.
  localparam logic [8:0] COND_PATS [COND_N] = '{
    9'b010011000, 9'b010110000, 9'b000110010, 9'b000011010,
    9'b001011001, 9'b111010000, 9'b100110100, 9'b000010111,
    9'b111011000, 9'b011011001, 9'b111110000, 9'b110110100,
    9'b100110110, 9'b000110111, 9'b000011111, 9'b001011011,
    9'b111011001, 9'b111110100, 9'b100110111, 9'b001011111,
    9'b011011011, 9'b111111000, 9'b110110110, 9'b000111111,
    9'b111011011, 9'b011011111, 9'b111111100, 9'b111111001,
    9'b111110110, 9'b110110111, 9'b100111111, 9'b001111111,
    9'b111011111, 9'b111111101, 9'b111110111, 9'b101111111,
    9'b111111011, 9'b111111110, 9'b110111111, 9'b011111111
  };

  typedef struct packed {
    logic [8:0] care;  // cells that must match val
    logic [8:0] val;
    logic [8:0] grp;   // at least one of these must be marked, if any
  } uncond_pat_t;

  localparam uncond_pat_t UNCOND_PATS [UNCOND_N] = '{
    '{9'b111111111, 9'b001010000, 9'b000000000},
    '{9'b111111111, 9'b100010000, 9'b000000000},
    '{9'b111111111, 9'b000010100, 9'b000000000},
    '{9'b111111111, 9'b000010001, 9'b000000000},
    '{9'b111111111, 9'b000010010, 9'b000000000},
    '{9'b111111111, 9'b000011000, 9'b000000000},
    '{9'b111111111, 9'b000110000, 9'b000000000},
    '{9'b111111111, 9'b010010000, 9'b000000000},
    '{9'b111111111, 9'b010011000, 9'b000000000},
    '{9'b111111111, 9'b000011010, 9'b000000000},
    '{9'b111111111, 9'b000110010, 9'b000000000},
    '{9'b111111111, 9'b010110000, 9'b000000000},
    '{9'b110110000, 9'b110110000, 9'b000000000},
    '{9'b000011011, 9'b000011011, 9'b000000000},
    '{9'b010111000, 9'b010111000, 9'b000000000},
    '{9'b000111010, 9'b000111010, 9'b000000000},
    '{9'b010110010, 9'b010110010, 9'b000000000},
    '{9'b010011010, 9'b010011010, 9'b000000000},
    '{9'b101010000, 9'b101010000, 9'b000000111},
    '{9'b001010001, 9'b001010001, 9'b100100100},
    '{9'b000010101, 9'b000010101, 9'b111000000},
    '{9'b100010100, 9'b100010100, 9'b001001001},
    '{9'b011111110, 9'b010011100, 9'b000000000},
    '{9'b110111011, 9'b010110001, 9'b000000000},
    '{9'b011111110, 9'b001110010, 9'b000000000},
    '{9'b110111011, 9'b100011010, 9'b000000000}
  };

  function automatic logic [8:0] rev9(logic [8:0] v);
    logic [8:0] r;
    for (int i = 0; i < 9; i++) r[8-i] = v[i];
    return r;
  endfunction

  // 3x3 window (bit m = row*3+col) exactly equals a conditional pattern
  function automatic logic cond_hit(logic [8:0] v);
    logic [8:0] vr;
    logic       hit;
    vr  = rev9(v);
    hit = 1'b0;
    for (int k = 0; k < COND_N; k++) begin
      if (vr == COND_PATS[k]) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic uncond_hit(logic [8:0] marks);
    logic [8:0] mr;
    logic       hit;
    mr  = rev9(marks);
    hit = 1'b0;
    for (int k = 0; k < UNCOND_N; k++) begin
      if (((mr & UNCOND_PATS[k].care) == UNCOND_PATS[k].val) &&
          ((UNCOND_PATS[k].grp == 9'd0) || ((mr & UNCOND_PATS[k].grp) != 9'd0)))
        hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

/* hdl/skel_win_if.sv */
`default_nettype none

interface skel_win_if;
  logic                          valid;
  logic                          ready;
  logic [skel_pkg::WIN_BITS-1:0] window;

  modport source (output valid, output window, input ready);
  modport sink   (input valid, input window, output ready);
endinterface

`default_nettype wire

/* hdl/skel_dec_if.sv */
`default_nettype none

interface skel_dec_if;
  logic valid;
  logic ready;
  logic pixel_next;
  logic erased;
  logic centre_marked;

  modport source (output valid, output pixel_next, output erased, output centre_marked,
                  input ready);
  modport sink   (input valid, input pixel_next, input erased, input centre_marked,
                  output ready);
endinterface

`default_nettype wire

/* hdl/skel_mark_array.sv */
`default_nettype none

// Conditional marks of the nine pixels around the centre, bit m = dr*3+dc.
module skel_mark_array (
  input  logic [skel_pkg::WIN_BITS-1:0] window_i,
  output logic [8:0]                    marks_o
);

  for (genvar r = 1; r <= 3; r++) begin : g_row
    for (genvar c = 1; c <= 3; c++) begin : g_col
      logic [8:0] nbhd;
      for (genvar m = 0; m < 9; m++) begin : g_nb
        assign nbhd[m] = window_i[(r - 1 + m / 3) * skel_pkg::WIN_DIM + (c - 1 + m % 3)];
      end
      // nbhd[4] is the pixel itself: only foreground can be marked
      assign marks_o[(r - 1) * 3 + (c - 1)] = nbhd[4] & skel_pkg::cond_hit(nbhd);
    end
  end

endmodule

`default_nettype wire

/* hdl/skeletonize_pass_pixel_decision_core.sv */
`default_nettype none

// Channel  Dir  Payload                              Handshake
// win_i    in   window[24:0]                         valid/ready
// dec_o    out  pixel_next, erased, centre_marked    valid/ready
//
// Three register stages: input window, 3x3 conditional marks, decision.
// One window is accepted per clock when dec_o is ready.
// Each stage advances when the stage after it is empty or moving, so a
// stall fills the bubbles first and then holds every stage in place.
// Reset clears the stage valid bits only.
module skeletonize_pass_pixel_decision_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  skel_win_if.sink    win_i,
  skel_dec_if.source  dec_o
);

  logic                          v1_q, v2_q, v3_q;
  logic                          rdy1, rdy2, rdy3;
  logic [skel_pkg::WIN_BITS-1:0] win1_q;
  logic [8:0]                    marks_d, marks2_q;
  logic                          centre2_q;
  logic                          erased_d;
  logic                          pixel_next_q, erased_q, centre_marked_q;

  assign rdy3 = !v3_q || dec_o.ready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign win_i.ready = rdy1;

  skel_mark_array u_marks (
    .window_i (win1_q),
    .marks_o  (marks_d)
  );

  assign erased_d = marks2_q[4] & ~skel_pkg::uncond_hit(marks2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= win_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && win_i.valid) win1_q <= win_i.window;
    if (rdy2 && v1_q) begin
      marks2_q  <= marks_d;
      centre2_q <= win1_q[skel_pkg::CTR_BIT];
    end
    if (rdy3 && v2_q) begin
      pixel_next_q    <= centre2_q & ~erased_d;
      erased_q        <= erased_d;
      centre_marked_q <= marks2_q[4];
    end
  end

  assign dec_o.valid         = v3_q;
  assign dec_o.pixel_next    = pixel_next_q;
  assign dec_o.erased        = erased_q;
  assign dec_o.centre_marked = centre_marked_q;

  a_erase_needs_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (!erased_q || centre_marked_q))
    else $error("erased without conditional mark");

  a_erase_clears_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> !(erased_q && pixel_next_q))
    else $error("erased pixel left in foreground");

  a_bg_unmarked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !centre2_q) |-> !marks2_q[4])
    else $error("background centre marked");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && !dec_o.ready) |-> !win_i.ready)
    else $error("request taken with pipeline full and stalled");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !rdy2) |=> (v2_q && $stable(marks2_q)))
    else $error("stalled mark stage changed");

endmodule

`default_nettype wire
